// ===== rtl/core/mma_pkg.sv =====
// Package for the matrix multiply-accumulate block: value formats, codes,
// register reset values and the saturation helper. No dependencies.
`default_nettype none

package mma_pkg;

    // Fixed-point format: signed Q16.16 held in 32 bits.
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * VALUE_BITS;
    // Width of a product after the fractional shift; every value that is
    // saturated is first sign-extended to this width.
    localparam int WIDE_W     = PROD_W - FRAC_BITS;
    // Dot product of up to eight terms needs three guard bits.
    localparam int ACC_W      = VALUE_BITS + 3;

    localparam int MAX_DIM_DEFAULT = 8;
    localparam int INDEX_BITS      = 3;
    localparam int DIM_BITS        = 4;
    localparam int CFG_INDEX_BITS  = 3;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [DIM_BITS-1:0]          dim_t;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_WRITE_C = 2'd2,
        OP_COMPUTE = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ALPHA        = 3'd0,
        CFG_A_TRANSPOSED = 3'd1,
        CFG_B_TRANSPOSED = 3'd2,
        CFG_OUT_ROWS     = 3'd3,
        CFG_INNER_LEN    = 3'd4,
        CFG_OUT_COLS     = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_WRITE
    } state_t;

    localparam value_t ALPHA_RESET = 32'sd65536;
    localparam dim_t   DIM_RESET   = 4'd8;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic value_t sat_value(input logic signed [WIDE_W-1:0] x);
        if (x[WIDE_W-1:VALUE_BITS-1] == {(WIDE_W-VALUE_BITS+1){x[WIDE_W-1]}}) begin
            return x[VALUE_BITS-1:0];
        end
        return x[WIDE_W-1] ? VALUE_MIN : VALUE_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mma_cmd_if.sv =====
// Input channel of the matrix multiply-accumulate block: element writes
// and compute commands. Depends on mma_pkg.
`default_nettype none

interface mma_cmd_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    mma_pkg::index_t        row_index;
    mma_pkg::index_t        col_index;
    mma_pkg::value_t        elem_value;

    modport source (output valid, output opcode, output row_index,
                    output col_index, output elem_value, input ready);
    modport sink   (input valid, input opcode, input row_index,
                    input col_index, input elem_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mma_rsp_if.sv =====
// Result channel of the matrix multiply-accumulate block: updated C
// elements in row-major order. Depends on mma_pkg.
`default_nettype none

interface mma_rsp_if;
    logic                   valid;
    logic                   ready;
    mma_pkg::index_t        out_row;
    mma_pkg::index_t        out_col;
    mma_pkg::value_t        out_value;
    logic                   last;

    modport source (output valid, output out_row, output out_col,
                    output out_value, output last, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input out_value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mma_cfg_if.sv =====
// Register write channel of the matrix multiply-accumulate block.
// Depends on mma_pkg.
`default_nettype none

interface mma_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mma_pkg::CFG_INDEX_BITS-1:0]  reg_index;
    mma_pkg::value_t                     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/matrix_multiply_accumulate.sv =====
// Matrix multiply-accumulate top level: C += alpha * op(A) * op(B) in Q16.16.
// Depends on mma_pkg and the interfaces mma_cmd_if, mma_rsp_if, mma_cfg_if.
// A compute command is paced by the single shared 32x32 multiplier, which does
// one product per cycle while a dot product is issued, and then the alpha scaling.
// rst_n clears the registers to their defaults and marks all of C as zero;
// A and B hold no defined contents until written.
`default_nettype none

module matrix_multiply_accumulate #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mma_cmd_if.sink     cmd,
    mma_cfg_if.sink     cfg,
    mma_rsp_if.source   rsp
);

    // Each matrix is stored row-major in a MAX_DIM x MAX_DIM memory.
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_DIM - 1);

    // Last valid loop index for a dimension register; zero and oversized
    // settings are clamped into 1..MAX_DIM.
    function automatic logic [IW-1:0] last_idx(input mma_pkg::dim_t d);
        mma_pkg::dim_t dm;
        dm = d - 4'd1;
        if (d == 4'd0) begin
            return '0;
        end
        if (d > 4'(MAX_DIM)) begin
            return IDX_MAX;
        end
        return dm[IW-1:0];
    endfunction

    // Row-major position of element (r, c).
    function automatic logic [AW-1:0] flat(input mma_pkg::index_t r,
                                           input mma_pkg::index_t c);
        logic [6:0] t;
        t = 7'(r) * 7'(MAX_DIM) + 7'(c);
        return t[AW-1:0];
    endfunction

    // Configuration registers. Writes are always accepted.
    mma_pkg::value_t alpha_reg;
    logic            a_trans_reg;
    logic            b_trans_reg;
    mma_pkg::dim_t   out_rows_reg;
    mma_pkg::dim_t   inner_len_reg;
    mma_pkg::dim_t   out_cols_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= mma_pkg::ALPHA_RESET;
            a_trans_reg   <= 1'b0;
            b_trans_reg   <= 1'b0;
            out_rows_reg  <= mma_pkg::DIM_RESET;
            inner_len_reg <= mma_pkg::DIM_RESET;
            out_cols_reg  <= mma_pkg::DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                mma_pkg::CFG_ALPHA:        alpha_reg     <= cfg.data;
                mma_pkg::CFG_A_TRANSPOSED: a_trans_reg   <= cfg.data[0];
                mma_pkg::CFG_B_TRANSPOSED: b_trans_reg   <= cfg.data[0];
                mma_pkg::CFG_OUT_ROWS:     out_rows_reg  <= cfg.data[3:0];
                mma_pkg::CFG_INNER_LEN:    inner_len_reg <= cfg.data[3:0];
                mma_pkg::CFG_OUT_COLS:     out_cols_reg  <= cfg.data[3:0];
                default:
                begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    logic [IW-1:0] i_last;
    logic [IW-1:0] j_last;
    logic [IW-1:0] k_last;

    assign i_last = last_idx(out_rows_reg);
    assign j_last = last_idx(inner_len_reg);
    assign k_last = last_idx(out_cols_reg);

    // Sequencer state. i and k walk the output elements in row-major order;
    // j walks the inner dimension, issuing one A/B read pair per cycle.
    mma_pkg::state_t state_reg;
    mma_pkg::state_t state_next;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   i_next;
    logic [IW-1:0]   j_reg;
    logic [IW-1:0]   j_next;
    logic [IW-1:0]   k_reg;
    logic [IW-1:0]   k_next;

    // Product pipeline: p1 marks read data in a_rd/b_rd, p2 marks a product
    // term in prod_reg waiting to be accumulated.
    logic p1_reg;
    logic p1_next;
    logic p2_reg;
    logic p2_next;

    logic signed [mma_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mma_pkg::ACC_W-1:0]  acc_next;
    logic signed [mma_pkg::PROD_W-1:0] prod_reg;
    logic signed [mma_pkg::PROD_W-1:0] prod_next;
    logic                              prod_en;

    // Result holding register; the sequencer only waits on it when a new
    // element is ready while the previous one has not been taken.
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    mma_pkg::index_t out_row_reg;
    mma_pkg::index_t out_col_reg;
    mma_pkg::value_t out_value_reg;
    logic            last_reg;
    logic            load_out;

    // Memories and their registered read data.
    logic [mma_pkg::VALUE_BITS-1:0] store_a_reg [DEPTH];
    logic [mma_pkg::VALUE_BITS-1:0] store_b_reg [DEPTH];
    logic [mma_pkg::VALUE_BITS-1:0] store_c_reg [DEPTH];
    logic [DEPTH-1:0]               c_valid_reg;
    mma_pkg::value_t                a_rd_reg;
    mma_pkg::value_t                b_rd_reg;
    mma_pkg::value_t                c_rd_reg;
    logic                           c_ok_reg;

    logic [AW-1:0]   a_addr;
    logic [AW-1:0]   b_addr;
    logic [AW-1:0]   c_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_in_range;
    logic            cmd_fire;
    logic            a_we;
    logic            b_we;
    logic            c_we;
    logic [AW-1:0]   c_wa;
    mma_pkg::value_t c_wd;

    // Shared arithmetic.
    mma_pkg::value_t                   mul_x;
    mma_pkg::value_t                   mul_y;
    mma_pkg::value_t                   prod_sat;
    mma_pkg::value_t                   dot_sat;
    mma_pkg::value_t                   c_val;
    logic signed [mma_pkg::WIDE_W-1:0] c_sum;
    mma_pkg::value_t                   new_c;
    logic                              elem_last;

    assign cmd.ready = (state_reg == mma_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign a_addr  = a_trans_reg ? flat(3'(j_reg), 3'(i_reg)) : flat(3'(i_reg), 3'(j_reg));
    assign b_addr  = b_trans_reg ? flat(3'(k_reg), 3'(j_reg)) : flat(3'(j_reg), 3'(k_reg));
    assign c_addr  = flat(3'(i_reg), 3'(k_reg));
    assign wr_addr = flat(cmd.row_index, cmd.col_index);

    // With a smaller MAX_DIM, writes outside the matrix are dropped.
    assign wr_in_range = (4'(cmd.row_index) < 4'(MAX_DIM))
                      && (4'(cmd.col_index) < 4'(MAX_DIM));

    assign a_we = cmd_fire && wr_in_range && (cmd.opcode == mma_pkg::OP_WRITE_A);
    assign b_we = cmd_fire && wr_in_range && (cmd.opcode == mma_pkg::OP_WRITE_B);

    // C is written either by an element write or by the update of one
    // result; the two never happen in the same cycle.
    assign c_we = load_out
               || (cmd_fire && wr_in_range && (cmd.opcode == mma_pkg::OP_WRITE_C));
    assign c_wa = load_out ? c_addr : wr_addr;
    assign c_wd = load_out ? new_c : cmd.elem_value;

    // The multiplier forms A*B terms while the pipeline runs and
    // alpha * dot once per output element in the scale step.
    assign mul_x     = (state_reg == mma_pkg::ST_SCALE) ? alpha_reg : a_rd_reg;
    assign mul_y     = (state_reg == mma_pkg::ST_SCALE) ? dot_sat : b_rd_reg;
    assign prod_next = mul_x * mul_y;
    assign prod_en   = p1_reg || (state_reg == mma_pkg::ST_SCALE);

    // Dropping the low 16 bits of the product is a floor shift, as required
    // both for the terms and for the alpha scaling.
    assign prod_sat  = mma_pkg::sat_value(prod_reg[mma_pkg::PROD_W-1:mma_pkg::FRAC_BITS]);
    assign dot_sat   = mma_pkg::sat_value(mma_pkg::WIDE_W'(acc_reg));
    assign c_val     = c_ok_reg ? c_rd_reg : '0;
    assign c_sum     = mma_pkg::WIDE_W'(c_val) + mma_pkg::WIDE_W'(prod_sat);
    assign new_c     = mma_pkg::sat_value(c_sum);
    assign elem_last = (i_reg == i_last) && (k_reg == k_last);

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            store_a_reg[wr_addr] <= cmd.elem_value;
        end
        if (b_we)
        begin
            store_b_reg[wr_addr] <= cmd.elem_value;
        end
        if (c_we)
        begin
            store_c_reg[c_wa] <= c_wd;
        end
        a_rd_reg <= store_a_reg[a_addr];
        b_rd_reg <= store_b_reg[b_addr];
        c_rd_reg <= store_c_reg[c_addr];
        c_ok_reg <= c_valid_reg[c_addr];
    end

    // An entry of C that was never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= '0;
        end
        else if (c_we)
        begin
            c_valid_reg[c_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mma_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (load_out)
        begin
            out_row_reg   <= 3'(i_reg);
            out_col_reg   <= 3'(k_reg);
            out_value_reg <= new_c;
            last_reg      <= elem_last;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        p1_next    = 1'b0;
        p2_next    = p1_reg;
        acc_next   = p2_reg ? acc_reg + mma_pkg::ACC_W'(prod_sat) : acc_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                if (cmd_fire && (cmd.opcode == mma_pkg::OP_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = mma_pkg::ST_MAC;
                end
            end
            mma_pkg::ST_MAC:
            begin
                p1_next = 1'b1;
                if (j_reg == j_last)
                begin
                    j_next     = '0;
                    state_next = mma_pkg::ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            mma_pkg::ST_DRAIN:
            begin
                if (!p1_reg && !p2_reg)
                begin
                    state_next = mma_pkg::ST_SCALE;
                end
            end
            mma_pkg::ST_SCALE:
            begin
                state_next = mma_pkg::ST_WRITE;
            end
            mma_pkg::ST_WRITE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    acc_next = '0;
                    if (k_reg == k_last)
                    begin
                        k_next = '0;
                        if (i_reg == i_last)
                        begin
                            i_next     = '0;
                            state_next = mma_pkg::ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = mma_pkg::ST_MAC;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = mma_pkg::ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = load_out || (rsp_valid_reg && !rsp.ready);

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_row   = out_row_reg;
    assign rsp.out_col   = out_col_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.last      = last_reg;

    // Read data only flows while products are being issued or drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_reg |-> (state_reg == mma_pkg::ST_MAC || state_reg == mma_pkg::ST_DRAIN))
        else $error("read data valid outside the product phase");

    // The scale step must see a fully accumulated dot product.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mma_pkg::ST_SCALE) |-> (!p1_reg && !p2_reg))
        else $error("scale step started with products still in flight");

    // A new command is only taken with the product pipeline empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> (!p1_reg && !p2_reg))
        else $error("command accepted while products are in flight");

    // The element flagged last ends the compute run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && elem_last) |=> (state_reg == mma_pkg::ST_IDLE))
        else $error("sequencer kept running after the last element");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for matrix_multiply_accumulate (C += alpha * op(A) * op(B), Q16.16).
// Depends on mma_pkg and the interfaces mma_cmd_if, mma_cfg_if and mma_rsp_if.
// A predictor in the bench computes each updated C element, and a checker compares the results.
`timescale 1ns / 100ps

module testbench;
    import mma_pkg::*;

    localparam int DIM           = MAX_DIM_DEFAULT;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    // The directed tests send about 160 commands; the random mix brings the total near 210.
    localparam int RANDOM_ITEMS  = 52;
    // This pause covers any write still inside the block after the last C element has left.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 5000000;

    localparam value_t Q_ONE = 32'sh0001_0000;

    // Register indexes past the end of the map. The block must ignore writes to them.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        index_t row;
        index_t col;
        value_t value;
        logic   last;
    } c_update_t;

    logic clk;
    logic rst_n;

    mma_cmd_if cmd_bus ();
    mma_cfg_if cfg_bus ();
    mma_rsp_if rsp_bus ();

    matrix_multiply_accumulate DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .cfg   (cfg_bus),
        .rsp   (rsp_bus)
    );

    // The bench keeps its own copy of the three matrices and the register file. They are
    // updated at the moment each transfer is accepted.
    value_t a_mem [DIM][DIM];
    value_t b_mem [DIM][DIM];
    value_t c_mem [DIM][DIM];
    value_t alpha_q;
    logic   a_trans;
    logic   b_trans;
    dim_t   rows_reg;
    dim_t   inner_reg;
    dim_t   cols_reg;

    // Updated C elements that are still to come out, oldest first.
    c_update_t c_updates_due [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    // When calm is set, neither side idles. This gives stretches at full rate.
    bit  calm = 1'b0;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case a transfer never completes or results go missing.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic value_t clip_q16(longint x);
        if (x > longint'(VALUE_MAX))
        begin
            return VALUE_MAX;
        end
        if (x < longint'(VALUE_MIN))
        begin
            return VALUE_MIN;
        end
        return value_t'(x);
    endfunction

    // A dimension register of zero counts as one. Anything above DIM counts as DIM.
    function automatic int dim_used(dim_t d);
        if (d == 0)
        begin
            return 1;
        end
        if (d > DIM)
        begin
            return DIM;
        end
        return int'(d);
    endfunction

    // Apply one accepted command to the shadow state. A compute command also queues
    // every C element that it updates, in row-major order.
    task automatic predict_c_updates(opcode_t op, index_t row, index_t col, value_t elem);
        int     m;
        int     n;
        int     p;
        longint dot;
        longint scaled;
        value_t av;
        value_t bv;
        value_t c_new;
        case (op)
            OP_WRITE_A: a_mem[row][col] = elem;
            OP_WRITE_B: b_mem[row][col] = elem;
            OP_WRITE_C: c_mem[row][col] = elem;
            OP_COMPUTE:
            begin
                m = dim_used(rows_reg);
                n = dim_used(inner_reg);
                p = dim_used(cols_reg);
                for (int i = 0; i < m; i++)
                begin
                    for (int k = 0; k < p; k++)
                    begin
                        dot = 0;
                        for (int j = 0; j < n; j++)
                        begin
                            av = a_trans ? a_mem[j][i] : a_mem[i][j];
                            bv = b_trans ? b_mem[k][j] : b_mem[j][k];
                            // Each product term is floored back to Q16.16 and
                            // saturated on its own before it is summed.
                            dot += clip_q16((longint'(av) * longint'(bv)) >>> FRAC_BITS);
                        end
                        dot    = clip_q16(dot);
                        scaled = clip_q16((longint'(alpha_q) * dot) >>> FRAC_BITS);
                        c_new  = clip_q16(longint'(c_mem[i][k]) + scaled);
                        c_mem[i][k] = c_new;
                        c_updates_due.push_back('{row: index_t'(i), col: index_t'(k),
                                                  value: c_new,
                                                  last: (i == m - 1) && (k == p - 1)});
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        c_update_t due;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (c_updates_due.size() == 0)
            begin
                $error("C element transfer with none due: row %0d col %0d value %0d",
                       rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value);
                mismatches++;
            end
            else
            begin
                due = c_updates_due.pop_front();
                if (rsp_bus.out_row !== due.row)
                begin
                    $error("out_row: expected %0d, got %0d", due.row, rsp_bus.out_row);
                    mismatches++;
                end
                if (rsp_bus.out_col !== due.col)
                begin
                    $error("out_col: expected %0d, got %0d", due.col, rsp_bus.out_col);
                    mismatches++;
                end
                if (rsp_bus.out_value !== due.value)
                begin
                    $error("out_value: expected %0d, got %0d", due.value, rsp_bus.out_value);
                    mismatches++;
                end
                if (rsp_bus.last !== due.last)
                begin
                    $error("last: expected %0d, got %0d", due.last, rsp_bus.last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Most gaps are short. A few are long enough to span a whole multiply-accumulate.
    function automatic int pick_gap();
        int roll;
        if (calm)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The result side stalls at random. A stall lasts for the number of cycles that
    // pick_gap returns.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap();
            end
        end
    end

    // Element values lean toward the saturation limits and small magnitudes. The rest
    // are full 32-bit patterns, so that every bit takes both values.
    function automatic value_t pick_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2, 3:    return value_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return value_t'($urandom());
        endcase
    endfunction

    function automatic value_t pick_alpha();
        case ($urandom_range(0, 7))
            0:       return Q_ONE;
            1:       return -Q_ONE;
            2:       return Q_ONE >>> 1;
            3:       return VALUE_MAX;
            4:       return VALUE_MIN;
            5:       return '0;
            6:       return value_t'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            default: return value_t'($urandom());
        endcase
    endfunction

    // Only the low nibble of a dimension write counts. The upper bits carry noise.
    // Small shapes are the usual case. Zero and sizes above DIM come up now and then.
    function automatic value_t pick_dim_word();
        value_t w;
        w = value_t'($urandom());
        case ($urandom_range(0, 9))
            0:       w[3:0] = 4'd0;
            1:       w[3:0] = 4'(DIM + $urandom_range(0, 15 - DIM));
            2:       w[3:0] = 4'(DIM);
            default: w[3:0] = 4'($urandom_range(1, 4));
        endcase
        return w;
    endfunction

    // Send one command. Valid stays high from one transfer to the next unless a gap is
    // drawn, so there is never more than one update to valid in the same step.
    task automatic send_cmd(opcode_t op, index_t row, index_t col, value_t elem);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= op;
        cmd_bus.row_index  <= row;
        cmd_bus.col_index  <= col;
        cmd_bus.elem_value <= elem;
        @(posedge clk);
        while (!cmd_bus.ready)
        begin
            @(posedge clk);
        end
        predict_c_updates(op, row, col, elem);
    endtask

    task automatic send_compute();
        send_cmd(OP_COMPUTE, index_t'($urandom()), index_t'($urandom()), value_t'($urandom()));
    endtask

    // Stop sending and wait until every updated C element has come back. Then let any
    // element write still in flight retire.
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (c_updates_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register. The shadow copy follows the same masking as the block: only
    // bit 0 of the transpose flags and the low nibble of the dimensions are kept.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, value_t data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.data      <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_ALPHA:        alpha_q   = data;
            CFG_A_TRANSPOSED: a_trans   = data[0];
            CFG_B_TRANSPOSED: b_trans   = data[0];
            CFG_OUT_ROWS:     rows_reg  = data[3:0];
            CFG_INNER_LEN:    inner_reg = data[3:0];
            CFG_OUT_COLS:     cols_reg  = data[3:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write every element of A and B once. After this, no compute can read an element
    // that was never written, whatever the shape or transpose.
    task automatic test_fill_stores();
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                send_cmd(OP_WRITE_A, index_t'(r), index_t'(c), pick_value());
                send_cmd(OP_WRITE_B, index_t'(r), index_t'(c), pick_value());
            end
        end
    endtask

    // Compute with the reset register values: alpha 1.0, no transpose, full 8x8x8.
    // C starts cleared, so this run also checks the reset state of C.
    task automatic test_reset_defaults();
        send_compute();
    endtask

    // Work with 1x1x1 shapes on element (0,0), so that each corner case gives exactly
    // one result: plain accumulate, saturation at both ends, products that overflow and
    // a negative product that floors to -1 LSB. Then the extremes of alpha.
    task automatic test_corner_values();
        wait_idle();
        write_reg(CFG_OUT_ROWS,  32'hFFFF_FFF1);
        write_reg(CFG_INNER_LEN, 32'h0000_0001);
        write_reg(CFG_OUT_COLS,  32'h8000_0001);

        send_cmd(OP_WRITE_A, 3'd0, 3'd0, Q_ONE);
        send_cmd(OP_WRITE_B, 3'd0, 3'd0, Q_ONE <<< 1);
        send_cmd(OP_WRITE_C, 3'd0, 3'd0, '0);
        send_compute();

        // Accumulating onto C at its positive limit must hold at the limit.
        send_cmd(OP_WRITE_C, 3'd0, 3'd0, VALUE_MAX);
        send_compute();

        // The largest product saturates before alpha is applied.
        send_cmd(OP_WRITE_A, 3'd0, 3'd0, VALUE_MAX);
        send_cmd(OP_WRITE_B, 3'd0, 3'd0, VALUE_MAX);
        send_compute();

        send_cmd(OP_WRITE_A, 3'd0, 3'd0, VALUE_MIN);
        send_cmd(OP_WRITE_C, 3'd0, 3'd0, VALUE_MIN);
        send_compute();

        // Negative times negative overflows toward the positive limit.
        send_cmd(OP_WRITE_B, 3'd0, 3'd0, VALUE_MIN);
        send_cmd(OP_WRITE_C, 3'd0, 3'd0, '0);
        send_compute();

        // -1 LSB times 1 LSB floors to -1 LSB, not to zero.
        send_cmd(OP_WRITE_A, 3'd0, 3'd0, -32'sd1);
        send_cmd(OP_WRITE_B, 3'd0, 3'd0, 32'sd1);
        send_cmd(OP_WRITE_C, 3'd0, 3'd0, '0);
        send_compute();

        // Writes at the far corners of all three stores.
        send_cmd(OP_WRITE_A, 3'd7, 3'd7, pick_value());
        send_cmd(OP_WRITE_B, 3'd7, 3'd0, pick_value());
        send_cmd(OP_WRITE_C, 3'd0, 3'd7, pick_value());

        send_cmd(OP_WRITE_A, 3'd0, 3'd0, Q_ONE <<< 3);
        send_cmd(OP_WRITE_B, 3'd0, 3'd0, -(Q_ONE <<< 2));
        wait_idle();
        write_reg(CFG_ALPHA, VALUE_MIN);
        send_compute();
        wait_idle();
        write_reg(CFG_ALPHA, VALUE_MAX);
        send_compute();
    endtask

    // Dimension registers of zero clamp to one, and values above DIM clamp to DIM.
    // Writes to the spare register indexes must change nothing. Both transposes are
    // used together on the full 8x8x8 shape, then neither is.
    task automatic test_dimension_clamp();
        wait_idle();
        write_reg(CFG_ALPHA,     Q_ONE >>> 2);
        write_reg(CFG_OUT_ROWS,  32'h0000_0030);
        write_reg(CFG_INNER_LEN, 32'hFFFF_FFF0);
        write_reg(CFG_OUT_COLS,  32'h0000_0000);
        send_compute();
        wait_idle();
        write_reg(CFG_OUT_ROWS,     32'h0000_000F);
        write_reg(CFG_INNER_LEN,    32'h7FFF_FFFF);
        write_reg(CFG_OUT_COLS,     32'h0000_0009);
        write_reg(CFG_A_TRANSPOSED, 32'hFFFF_FFFF);
        write_reg(CFG_B_TRANSPOSED, 32'h0000_0001);
        write_reg(CFG_SPARE_LO,     VALUE_MIN);
        write_reg(CFG_SPARE_HI,     value_t'($urandom()));
        send_compute();
        wait_idle();
        write_reg(CFG_A_TRANSPOSED, 32'h0000_0000);
        write_reg(CFG_B_TRANSPOSED, 32'hFFFF_FFFE);
        send_compute();
    endtask

    // Draw a new register setting. The caller must make sure the block is idle first.
    task automatic reshuffle_config();
        write_reg(CFG_ALPHA,        pick_alpha());
        write_reg(CFG_A_TRANSPOSED, value_t'($urandom()));
        write_reg(CFG_B_TRANSPOSED, value_t'($urandom()));
        write_reg(CFG_OUT_ROWS,     pick_dim_word());
        write_reg(CFG_INNER_LEN,    pick_dim_word());
        write_reg(CFG_OUT_COLS,     pick_dim_word());
    endtask

    // Random mix of element writes and computes. Every element of A and B has already
    // been written, so any shape is legal. Now and then the sender drains, the
    // registers are redrawn and the idling mode is drawn anew.
    task automatic test_random_traffic();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 17) == 0)
            begin
                wait_idle();
                reshuffle_config();
                calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 14)
            begin
                send_compute();
            end
            else
            begin
                send_cmd(opcode_t'($urandom_range(OP_WRITE_A, OP_WRITE_C)),
                         index_t'($urandom()), index_t'($urandom()), pick_value());
            end
            sent++;
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.opcode     = OP_WRITE_A;
        cmd_bus.row_index  = '0;
        cmd_bus.col_index  = '0;
        cmd_bus.elem_value = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.reg_index  = CFG_ALPHA;
        cfg_bus.data       = '0;
        rsp_bus.ready      = 1'b0;

        // Shadow state after reset. C is cleared. A and B are only read after
        // test_fill_stores has written every element.
        alpha_q   = ALPHA_RESET;
        a_trans   = 1'b0;
        b_trans   = 1'b0;
        rows_reg  = DIM_RESET;
        inner_reg = DIM_RESET;
        cols_reg  = DIM_RESET;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                a_mem[r][c] = '0;
                b_mem[r][c] = '0;
                c_mem[r][c] = '0;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_fill_stores();
        test_reset_defaults();
        test_corner_values();
        test_dimension_clamp();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
